@@ rtl/core/rnp_pkg.sv @@
// ----------------------------------------------------------------------------
// rnp_pkg - shared types and constants of the radix number parser
// Character codes, parse phases, radix and suffix codes, and the state and
// result records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package rnp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;

  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CharW-1:0] CHAR_LO_F  = 8'h66;
  localparam logic [CharW-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CharW-1:0] CHAR_UP_F  = 8'h46;
  localparam logic [CharW-1:0] CHAR_LO_X  = 8'h78;
  localparam logic [CharW-1:0] CHAR_LO_K  = 8'h6b;
  localparam logic [CharW-1:0] CHAR_UP_K  = 8'h4b;
  localparam logic [CharW-1:0] CHAR_LO_M  = 8'h6d;
  localparam logic [CharW-1:0] CHAR_UP_M  = 8'h4d;
  localparam logic [CharW-1:0] CHAR_LO_G  = 8'h67;
  localparam logic [CharW-1:0] CHAR_UP_G  = 8'h47;

  localparam logic [ValueW-1:0] LIMIT_K = ValueW'(4 * 1024 * 1024);
  localparam logic [ValueW-1:0] LIMIT_M = ValueW'(4 * 1024);
  localparam logic [ValueW-1:0] LIMIT_G = ValueW'(4);

  localparam int unsigned ShiftK = 10;
  localparam int unsigned ShiftM = 20;
  localparam int unsigned ShiftG = 30;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ZERO  = 2'd1,
    PH_HEX0X = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef enum logic [1:0] {
    SUF_NONE = 2'd0,
    SUF_K    = 2'd1,
    SUF_M    = 2'd2,
    SUF_G    = 2'd3
  } suffix_t;

  typedef struct packed {
    phase_t              parse_phase;
    base_t               number_base;
    logic [ValueW-1:0]   running_value;
    logic                error_seen;
    suffix_t             pending_suffix;
  } rnp_state_t;

  typedef struct packed {
    logic                done;
    logic [ValueW-1:0]   number_value;
    logic                parse_error;
  } rnp_result_t;

  localparam rnp_state_t STATE_CLEAR = '{
    parse_phase:    PH_START,
    number_base:    BASE_DEC,
    running_value:  '0,
    error_seen:     1'b0,
    pending_suffix: SUF_NONE
  };

endpackage

@@ rtl/core/rnp_step.sv @@
// ----------------------------------------------------------------------------
// rnp_step - one character step of the radix number parser
// Decodes the prefix, digits and unit suffix of one character, advances the
// running value by a shift-add multiply and, on the terminator, forms the
// scaled and range-checked result.
// ----------------------------------------------------------------------------
module rnp_step (
  input  logic [rnp_pkg::CharW-1:0] char_code,
  input  rnp_pkg::rnp_state_t       state_cur,
  output rnp_pkg::rnp_state_t       state_next,
  output rnp_pkg::rnp_result_t      result
);
  import rnp_pkg::*;

  logic              is_term;
  logic              use_body;
  base_t             base_eff;
  suffix_t           suf_code;
  logic              is_dec;
  logic              is_lo_hex;
  logic              is_up_hex;
  logic [3:0]        digit;
  logic              digit_ok;
  logic [ValueW-1:0] prev;
  logic [ValueW-1:0] scaled;
  logic [ValueW-1:0] sum;
  logic              fin_err;
  logic [ValueW-1:0] fin_val;

  assign is_term   = (char_code == CHAR_NUL);
  assign is_dec    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_lo_hex = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_F);
  assign is_up_hex = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F);
  assign prev      = state_cur.running_value;

  always_comb begin
    if (char_code == CHAR_LO_K || char_code == CHAR_UP_K) begin
      suf_code = SUF_K;
    end else if (char_code == CHAR_LO_M || char_code == CHAR_UP_M) begin
      suf_code = SUF_M;
    end else if (char_code == CHAR_LO_G || char_code == CHAR_UP_G) begin
      suf_code = SUF_G;
    end else begin
      suf_code = SUF_NONE;
    end
  end

  // the body uses decimal when the string opens with a non-zero character
  assign base_eff = (state_cur.parse_phase == PH_START) ? BASE_DEC : state_cur.number_base;

  always_comb begin
    digit    = '0;
    digit_ok = 1'b0;
    scaled   = prev * 32'd10;
    case (base_eff)
      BASE_OCT: begin
        scaled = prev << 3;
        if (is_dec) begin
          digit    = 4'(char_code - CHAR_ZERO);
          digit_ok = (digit < 4'd8);
        end
      end
      BASE_HEX: begin
        scaled = prev << 4;
        if (is_dec) begin
          digit    = 4'(char_code - CHAR_ZERO);
          digit_ok = 1'b1;
        end else if (is_lo_hex) begin
          digit    = 4'(char_code - CHAR_LO_A + 8'd10);
          digit_ok = 1'b1;
        end else if (is_up_hex) begin
          digit    = 4'(char_code - CHAR_UP_A + 8'd10);
          digit_ok = 1'b1;
        end
      end
      default: begin
        scaled = (prev << 3) + (prev << 1);
        if (is_dec) begin
          digit    = 4'(char_code - CHAR_ZERO);
          digit_ok = 1'b1;
        end
      end
    endcase
  end

  assign sum = scaled + ValueW'(digit);

  always_comb begin
    fin_err = state_cur.error_seen
           || (state_cur.parse_phase == PH_START)
           || (state_cur.parse_phase == PH_HEX0X);
    fin_val = prev;
    if (!fin_err) begin
      case (state_cur.pending_suffix)
        SUF_K: begin
          if (prev >= LIMIT_K) fin_err = 1'b1;
          else fin_val = prev << ShiftK;
        end
        SUF_M: begin
          if (prev >= LIMIT_M) fin_err = 1'b1;
          else fin_val = prev << ShiftM;
        end
        SUF_G: begin
          if (prev >= LIMIT_G) fin_err = 1'b1;
          else fin_val = prev << ShiftG;
        end
        default: begin
          fin_val = prev;
        end
      endcase
    end
    if (fin_err) fin_val = '0;
  end

  always_comb begin
    result.done         = is_term;
    result.number_value = fin_val;
    result.parse_error  = fin_err;
  end

  always_comb begin
    state_next = state_cur;
    use_body   = 1'b0;
    if (is_term) begin
      state_next = STATE_CLEAR;
    end else begin
      case (state_cur.parse_phase)
        PH_START: begin
          if (char_code == CHAR_ZERO) begin
            state_next.parse_phase = PH_ZERO;
            state_next.number_base = BASE_OCT;
          end else begin
            state_next.number_base = BASE_DEC;
            use_body = 1'b1;
          end
        end
        PH_ZERO: begin
          if (char_code == CHAR_LO_X) begin
            state_next.parse_phase = PH_HEX0X;
            state_next.number_base = BASE_HEX;
          end else begin
            use_body = 1'b1;
          end
        end
        default: begin
          use_body = 1'b1;
        end
      endcase
      if (use_body) begin
        state_next.parse_phase = PH_BODY;
        if (!state_cur.error_seen) begin
          if (state_cur.pending_suffix != SUF_NONE) begin
            state_next.error_seen = 1'b1;
          end else if (suf_code != SUF_NONE) begin
            state_next.pending_suffix = suf_code;
          end else if (!digit_ok || (sum < prev)) begin
            state_next.error_seen = 1'b1;
          end else begin
            state_next.running_value = sum;
          end
        end
      end
    end
  end

endmodule

@@ rtl/core/radix_number_parser_with_units.sv @@
// ----------------------------------------------------------------------------
// radix_number_parser_with_units - octal, decimal and hex number parser
// Parses a zero-terminated character string with an optional k, m or g unit
// suffix and returns the scaled value and an error flag per string.
//
//   channel   signals                                 direction
//   char      char_valid, char_ready, char_code       request in
//   result    result_valid, result_ready,             request out
//             number_value, parse_error
//
// One character per cycle while no terminator waits; a result is offered when
// its terminator moves from the character register into the result register.
// Each step is a shift-add multiply by 8, 10 or 16 between the character
// register and the parser state register.
// A terminator waits in the character register while the result register is
// full and not taken; other characters never wait.
// Reset clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
module radix_number_parser_with_units (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  output logic                       char_ready,
  input  logic [rnp_pkg::CharW-1:0]  char_code,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [rnp_pkg::ValueW-1:0] number_value,
  output logic                       parse_error
);
  import rnp_pkg::*;

  logic             char_q_valid;
  logic [CharW-1:0] char_q;
  rnp_state_t       state;
  rnp_state_t       state_next;
  rnp_result_t      step_result;
  logic             advance;

  rnp_step u_step (
    .char_code  (char_q),
    .state_cur  (state),
    .state_next (state_next),
    .result     (step_result)
  );

  assign advance    = char_q_valid && (!step_result.done || !result_valid || result_ready);
  assign char_ready = !rst && (!char_q_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_q_valid <= 1'b0;
      result_valid <= 1'b0;
      state        <= STATE_CLEAR;
    end else begin
      if (char_valid && char_ready) begin
        char_q_valid <= 1'b1;
        char_q       <= char_code;
      end else if (advance) begin
        char_q_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && step_result.done) begin
        result_valid <= 1'b1;
        number_value <= step_result.number_value;
        parse_error  <= step_result.parse_error;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/rnp_checker.sv @@
// ----------------------------------------------------------------------------
// rnp_checker - port-level checks for the radix number parser
// Watches the character and result channels of the top level; bound to it.
// ----------------------------------------------------------------------------
module rnp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       char_valid,
  input logic                       char_ready,
  input logic [rnp_pkg::CharW-1:0]  char_code,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [rnp_pkg::ValueW-1:0] number_value,
  input logic                       parse_error
);
  import rnp_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(number_value) && $stable(parse_error))
    else $error("result request changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_error |-> number_value == '0)
    else $error("error result carries a non-zero value");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      $past(char_valid && char_ready && (char_code == CHAR_NUL), 2))
    else $error("result without a terminator two cycles before");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !char_ready |-> result_valid && !result_ready)
    else $error("character channel stalled without a blocked result");

endmodule

bind radix_number_parser_with_units rnp_checker u_rnp_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_ready   (char_ready),
  .char_code    (char_code),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .number_value (number_value),
  .parse_error  (parse_error)
);
